// ----- hdl/tpi_pkg.sv -----
// tpi_pkg: request/response types, status and register codes and unit widths
// for the table interpolator. No dependencies.
`timescale 1ns / 1ps
package tpi_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FEW   = 2'd2;
  localparam status_t ST_SAT   = 2'd3;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 4'd1;

  // magnitude width of quotients and products, limit is 2^47-1 raw
  localparam int MAG_W = 48;
  localparam logic [MAG_W-1:0] LIM_MAG = 48'h7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0] ONE_Q16 = 48'h0000_0001_0000;

  typedef struct packed {
    logic               operation;
    logic [7:0]         point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } tpi_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    status_t            status;
  } tpi_rsp_t;

  // result of the divide or multiply unit
  typedef struct packed {
    logic             done;
    logic             sat;
    logic [MAG_W-1:0] mag;
  } tpi_unit_rsp_t;

endpackage

// ----- hdl/table_poly_interpolator_1d.sv -----
// Table interpolator: a load leaves busy low and gives no result.
// Query: too few points answer with ST_FEW; else setup and end reads, a
// bisection of up to 9 steps for 256 points, then d+1 terms, each of d factors
// (a divide, then a multiply) and a multiply by the ordinate, and a final
// saturation step. One query at a time; one result strobe per query,
// receiver cannot stall. Reset: points_in_use 2, degree 1.
`timescale 1ns / 1ps
module table_poly_interpolator_1d
  import tpi_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int MAX_DEGREE = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tpi_req_t              req_i,
  output logic                  result_valid_o,
  output tpi_rsp_t              rsp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int IW    = $clog2(MAX_POINTS + MAX_DEGREE + 2) + 1;
  localparam int SUM_W = MAG_W + $clog2(MAX_DEGREE + 1) + 1;
  localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] RES_MIN = ~RES_MAX;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_L0, S_L1, S_L2, S_L3, S_L4, S_BIS, S_BCMP, S_RANGE,
    S_TI, S_TIW, S_TJ, S_TJW, S_DIV, S_MULC, S_TMUL, S_MULY, S_FIN
  } state_e;

  state_e state_q;
  logic [8:0] pts_q;
  logic [2:0] deg_q;
  logic signed [31:0] x_q, a0_q, a1_q, an_q, xi_q, yi_q;
  logic snap0_q, up_q, sat_q, c_neg_q, p_neg_q;
  logic signed [IW-1:0] lo_q, hi_q, mid_q, ix_q, i_q, j_q;
  logic [MAG_W-1:0] c_mag_q;
  logic signed [SUM_W-1:0] sum_q;
  logic rvalid_q;
  tpi_rsp_t rsp_q;

  logic accept, mem_we;
  logic [AW-1:0] rd_addr;
  logic [63:0] rdata;
  logic signed [31:0] rd_x;
  logic signed [IW-1:0] n_s, d_s, nm1_s, nm2_s, mid_s, ixi_s, ixj_s, nmd_s;
  logic signed [IW:0] hl_sum;
  logic signed [32:0] den_s, num_s;
  logic few, snap_last;
  logic div_start, mul_start;
  logic [MAG_W-1:0] mul_a, mul_b;
  logic signed [SUM_W-1:0] term_s;
  tpi_unit_rsp_t div_rsp, mul_rsp;

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v < 0 ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [39:0] x100(logic [32:0] m);
    return (40'(m) << 6) + (40'(m) << 5) + (40'(m) << 2);
  endfunction

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign mem_we      = accept && req_i.operation == OP_LOAD
                       && int'(req_i.point_index) < MAX_POINTS;

  tpi_mem #(.DEPTH(MAX_POINTS), .DATA_W(64)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(req_i.point_index)),
    .wdata_i ({req_i.x_value, req_i.y_value}),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign rd_x   = signed'(rdata[63:32]);
  assign n_s    = (int'(pts_q) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(pts_q);
  assign d_s    = (int'(deg_q) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(deg_q);
  assign nm1_s  = n_s - IW'(1);
  assign nm2_s  = n_s - IW'(2);
  assign nmd_s  = n_s - d_s;
  assign hl_sum = {hi_q[IW-1], hi_q} + {lo_q[IW-1], lo_q};
  assign mid_s  = hl_sum[IW:1];
  assign ixi_s  = ix_q + i_q;
  assign ixj_s  = ix_q + j_q;
  assign few    = (n_s < IW'(2)) || (n_s <= d_s);
  assign den_s  = {xi_q[31], xi_q} - {rd_x[31], rd_x};
  assign num_s  = {x_q[31], x_q} - {rd_x[31], rd_x};
  assign snap_last = x100(mag33({x_q[31], x_q} - {an_q[31], an_q}))
                     < 40'(mag33({rd_x[31], rd_x} - {an_q[31], an_q}));
  assign term_s = signed'(SUM_W'(mul_rsp.mag));

  always_comb begin
    rd_addr   = '0;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_a     = c_mag_q;
    mul_b     = div_rsp.mag;
    case (state_q)
      S_L1:   rd_addr = AW'(1);
      S_L2:   rd_addr = nm1_s[AW-1:0];
      S_L3:   rd_addr = nm2_s[AW-1:0];
      S_BIS:  rd_addr = mid_s[AW-1:0];
      S_TI:   rd_addr = ixi_s[AW-1:0];
      S_TJ:   rd_addr = ixj_s[AW-1:0];
      S_TJW:  div_start = den_s != 0;
      S_DIV:  mul_start = div_rsp.done;
      S_TMUL: begin
        mul_start = 1'b1;
        mul_a     = MAG_W'(mag33({yi_q[31], yi_q}));
        mul_b     = c_mag_q;
      end
      default: rd_addr = '0;
    endcase
  end

  tpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mag33(num_s)),
    .den_i   (mag33(den_s)),
    .rsp_o   (div_rsp)
  );

  tpi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .rsp_o   (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pts_q    <= 9'd2;
      deg_q    <= 3'd1;
      rvalid_q <= 1'b0;
      rsp_q    <= '0;
      x_q      <= '0;
      a0_q     <= '0;
      a1_q     <= '0;
      an_q     <= '0;
      xi_q     <= '0;
      yi_q     <= '0;
      snap0_q  <= 1'b0;
      up_q     <= 1'b0;
      sat_q    <= 1'b0;
      c_neg_q  <= 1'b0;
      p_neg_q  <= 1'b0;
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
      ix_q     <= '0;
      i_q      <= '0;
      j_q      <= '0;
      c_mag_q  <= '0;
      sum_q    <= '0;
    end else begin
      rvalid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_POINTS: pts_q <= cfg_data_i[8:0];
          REG_DEGREE: deg_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept && req_i.operation == OP_QUERY) begin
            x_q     <= req_i.x_value;
            sat_q   <= 1'b0;
            sum_q   <= '0;
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (few) begin
            rsp_q    <= '{result_value: '0, status: ST_FEW};
            rvalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_L0;
          end
        end
        S_L0: state_q <= S_L1;
        S_L1: begin
          a0_q    <= rd_x;
          state_q <= S_L2;
        end
        S_L2: begin
          a1_q    <= rd_x;
          state_q <= S_L3;
        end
        S_L3: begin
          an_q    <= rd_x;
          snap0_q <= x100(mag33({x_q[31], x_q} - {a0_q[31], a0_q}))
                     < 40'(mag33({a1_q[31], a1_q} - {a0_q[31], a0_q}));
          state_q <= S_L4;
        end
        S_L4: begin
          // rdata holds the next-to-last abscissa here
          up_q <= an_q > a0_q;
          lo_q <= IW'(-1);
          hi_q <= n_s;
          if (snap0_q) begin
            lo_q    <= '0;
            state_q <= S_RANGE;
          end else if (snap_last) begin
            lo_q    <= nm2_s;
            state_q <= S_RANGE;
          end else begin
            state_q <= S_BIS;
          end
        end
        S_BIS: begin
          if (hi_q - lo_q > IW'(1)) begin
            mid_q   <= mid_s;
            state_q <= S_BCMP;
          end else begin
            state_q <= S_RANGE;
          end
        end
        S_BCMP: begin
          if ((x_q > rd_x) == up_q) begin
            lo_q <= mid_q;
          end else begin
            hi_q <= mid_q;
          end
          state_q <= S_BIS;
        end
        S_RANGE: begin
          if (lo_q < 0 || lo_q >= nm1_s) begin
            rsp_q    <= '{result_value: '0, status: ST_RANGE};
            rvalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            ix_q    <= (lo_q >= nmd_s) ? nmd_s - IW'(1) : lo_q;
            i_q     <= '0;
            state_q <= S_TI;
          end
        end
        S_TI: state_q <= S_TIW;
        S_TIW: begin
          xi_q    <= rd_x;
          yi_q    <= signed'(rdata[31:0]);
          c_mag_q <= ONE_Q16;
          c_neg_q <= 1'b0;
          j_q     <= '0;
          state_q <= S_TJ;
        end
        S_TJ: begin
          if (j_q > d_s) begin
            state_q <= S_TMUL;
          end else if (j_q == i_q) begin
            j_q <= j_q + IW'(1);
          end else begin
            state_q <= S_TJW;
          end
        end
        S_TJW: begin
          if (den_s == 0) begin
            // repeated abscissa among the selected points
            rsp_q    <= '{result_value: '0, status: ST_SAT};
            rvalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            p_neg_q <= (num_s < 0) != (den_s < 0);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            sat_q   <= sat_q | div_rsp.sat;
            // p_neg_q becomes the product sign; zero quotient is positive
            p_neg_q <= c_neg_q ^ (p_neg_q && div_rsp.mag != '0);
            state_q <= S_MULC;
          end
        end
        S_MULC: begin
          if (mul_rsp.done) begin
            sat_q   <= sat_q | mul_rsp.sat;
            c_mag_q <= mul_rsp.mag;
            c_neg_q <= p_neg_q && mul_rsp.mag != '0;
            j_q     <= j_q + IW'(1);
            state_q <= S_TJ;
          end
        end
        S_TMUL: begin
          p_neg_q <= (yi_q < 0) != c_neg_q;
          state_q <= S_MULY;
        end
        S_MULY: begin
          if (mul_rsp.done) begin
            sat_q <= sat_q | mul_rsp.sat;
            sum_q <= p_neg_q ? sum_q - term_s : sum_q + term_s;
            if (i_q == d_s) begin
              state_q <= S_FIN;
            end else begin
              i_q     <= i_q + IW'(1);
              state_q <= S_TI;
            end
          end
        end
        S_FIN: begin
          rvalid_q <= 1'b1;
          state_q  <= S_IDLE;
          if (sum_q > RES_MAX) begin
            rsp_q <= '{result_value: RES_MAX[31:0], status: ST_SAT};
          end else if (sum_q < RES_MIN) begin
            rsp_q <= '{result_value: RES_MIN[31:0], status: ST_SAT};
          end else begin
            rsp_q <= '{result_value: sum_q[31:0], status: sat_q ? ST_SAT : ST_OK};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = rvalid_q;
  assign rsp_o          = rsp_q;

endmodule

// ----- hdl/tpi_mem.sv -----
// tpi_mem: grid table memory, one write and one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module tpi_mem #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tpi_div.sv -----
// tpi_div: restoring divider, one quotient bit per cycle, rounded Q16.16
// quotient magnitude saturated at the limit. Depends on tpi_pkg.
`timescale 1ns / 1ps
module tpi_div
  import tpi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [32:0]   num_i,
  input  logic [32:0]   den_i,
  output tpi_unit_rsp_t rsp_o
);

  localparam int N_W = 50;
  localparam int D_W = 34;
  localparam int R_W = D_W + 1;
  localparam int C_W = $clog2(N_W);

  logic           busy_q, done_q;
  logic [C_W-1:0] cnt_q;
  logic [N_W-1:0] dvd_q, quo_q;
  logic [D_W-1:0] dvs_q;
  logic [R_W-1:0] rem_q;
  logic [R_W-1:0] rem_sh;
  logic           fits;

  assign rem_sh = {rem_q[R_W-2:0], dvd_q[N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        // ((num << 17) + den) / (den << 1) rounds to nearest
        dvd_q  <= {num_i, 17'b0} + {17'b0, den_i};
        dvs_q  <= {den_i, 1'b0};
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[N_W-2:0], 1'b0};
        rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
        quo_q <= {quo_q[N_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == C_W'(N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.sat  = quo_q > {2'b0, LIM_MAG};
    rsp_o.mag  = rsp_o.sat ? LIM_MAG : quo_q[MAG_W-1:0];
  end

endmodule

// ----- hdl/tpi_mul.sv -----
// tpi_mul: 48x48 magnitude multiplier, one 16-bit digit of b per cycle,
// result rounded by 16 fraction bits and saturated. Depends on tpi_pkg.
`timescale 1ns / 1ps
module tpi_mul
  import tpi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] a_i,
  input  logic [MAG_W-1:0] b_i,
  output tpi_unit_rsp_t    rsp_o
);

  localparam int DIG_W  = 16;
  localparam int DIGITS = MAG_W / DIG_W;
  localparam int P_W    = 2 * MAG_W;
  localparam int C_W    = $clog2(DIGITS);

  logic             busy_q, done_q;
  logic [C_W-1:0]   cnt_q;
  logic [MAG_W-1:0] a_q, b_q;
  logic [P_W-1:0]   acc_q;
  logic [P_W-1:0]   rnd;
  logic [P_W-DIG_W-1:0] r_full;
  logic [MAG_W+DIG_W-1:0] part;

  assign part = a_q * b_q[MAG_W-1 -: DIG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        // top digit first
        acc_q <= {acc_q[P_W-DIG_W-1:0], {DIG_W{1'b0}}} + P_W'(part);
        b_q   <= {b_q[MAG_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == C_W'(DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rnd    = acc_q + P_W'(32768);
  assign r_full = rnd[P_W-1:DIG_W];

  always_comb begin
    rsp_o.done = done_q;
    rsp_o.sat  = r_full > (P_W-DIG_W)'(LIM_MAG);
    rsp_o.mag  = rsp_o.sat ? LIM_MAG : r_full[MAG_W-1:0];
  end

endmodule

// ----- hdl/tpi_chk.sv -----
// tpi_chk: port-level assertions for table_poly_interpolator_1d, bound to it.
// Depends on tpi_pkg.
`timescale 1ns / 1ps
module tpi_chk
  import tpi_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input tpi_req_t req_i,
  input logic     result_valid_o,
  input tpi_rsp_t rsp_o
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == OP_QUERY) |=> busy)
    else $error("query request did not make the block busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == OP_LOAD) |=> !busy)
    else $error("load request made the block busy");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a query in flight");

  a_zero_on_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == ST_FEW || rsp_o.status == ST_RANGE))
    |-> rsp_o.result_value == 0)
    else $error("flagged result carries a nonzero value");

endmodule

bind table_poly_interpolator_1d tpi_chk u_tpi_chk (.*);
